### rtl/stpd_pkg.sv
package stpd_pkg;

  // Configuration port layout
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_WAIT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_EXTRA = 2'd2;

  // Register reset values, in ticks
  localparam int DEBOUNCE_RESET   = 30;
  localparam int SHORT_WAIT_RESET = 700;
  localparam int LONG_EXTRA_RESET = 1300;

  // Result layout
  localparam int OUT_CMD_BITS = 32;
  localparam int WIDE_BITS    = 64;

  // Gap timer mode
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SHORT = 2'd1,
    MODE_LONG  = 2'd2
  } wait_mode_t;

  // One tick's worth of debounced information, front to back
  typedef struct packed {
    logic toggle;
  } tick_evt_t;

endpackage

### rtl/switch_tap_pattern_decoder_core.sv
// Channel   Signals                                      Direction
// tick      tick_valid, tick_stall, level                sample in, one per ms tick
// cmd       cmd_valid, cmd_stall, command, overflowed    finished command out
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data    register write in
//
// One tick per clock cycle sustained while tick_stall is low; the debounce front and
// the gap timer back each advance once per accepted tick, joined by a two-entry queue.
// A result leaves through a single output register; the back holds while that
// register is full and stalled, and the front stalls once the queue is full.
// Reset (rst, synchronous) restores registers to 30 / 700 / 1300 ticks and
// idles both levels high. cfg_ready is always high.
module switch_tap_pattern_decoder_core #(
  parameter int CMD_BITS   = 32,
  parameter int TIMER_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick_valid,
  output logic                                tick_stall,
  input  logic                                level,
  output logic                                cmd_valid,
  input  logic                                cmd_stall,
  output logic [stpd_pkg::OUT_CMD_BITS-1:0]   command,
  output logic                                overflowed,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [stpd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic [TIMER_BITS-1:0] debounce_ticks;
  logic [TIMER_BITS-1:0] short_wait_ticks;
  logic [TIMER_BITS-1:0] long_extra_ticks;

  logic                  take;
  stpd_pkg::tick_evt_t   push_evt;
  stpd_pkg::tick_evt_t   pop_evt;
  logic                  q_empty;
  logic                  q_full;
  logic                  q_pop;

  assign cfg_ready  = 1'b1;
  assign tick_stall = q_full;
  assign take       = tick_valid && !q_full;

  // Configuration registers, truncated to the timer width
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= TIMER_BITS'(stpd_pkg::DEBOUNCE_RESET);
      short_wait_ticks <= TIMER_BITS'(stpd_pkg::SHORT_WAIT_RESET);
      long_extra_ticks <= TIMER_BITS'(stpd_pkg::LONG_EXTRA_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stpd_pkg::REG_DEBOUNCE:   debounce_ticks   <= TIMER_BITS'(cfg_data);
        stpd_pkg::REG_SHORT_WAIT: short_wait_ticks <= TIMER_BITS'(cfg_data);
        stpd_pkg::REG_LONG_EXTRA: long_extra_ticks <= TIMER_BITS'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  stpd_front #(
    .TIMER_BITS(TIMER_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .level         (level),
    .debounce_ticks(debounce_ticks),
    .evt           (push_evt)
  );

  stpd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (take),
    .push_evt(push_evt),
    .pop     (q_pop),
    .pop_evt (pop_evt),
    .empty   (q_empty),
    .full    (q_full)
  );

  stpd_back #(
    .CMD_BITS  (CMD_BITS),
    .TIMER_BITS(TIMER_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .evt_avail       (!q_empty),
    .evt             (pop_evt),
    .evt_pop         (q_pop),
    .short_wait_ticks(short_wait_ticks),
    .long_extra_ticks(long_extra_ticks),
    .cmd_valid       (cmd_valid),
    .cmd_stall       (cmd_stall),
    .command         (command),
    .overflowed      (overflowed)
  );

endmodule

### rtl/stpd_front.sv
module stpd_front #(
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic                  level,
  input  logic [TIMER_BITS-1:0] debounce_ticks,
  output stpd_pkg::tick_evt_t   evt
);

  logic                  previous_raw;
  logic                  stable_level;
  logic                  debouncing;
  logic [TIMER_BITS-1:0] debounce_count;

  logic                  stable_level_next;
  logic                  debouncing_next;
  logic [TIMER_BITS-1:0] debounce_count_next;
  logic                  toggle;

  // Debounce: start on an edge, ignore edges while counting, sample at the end
  always_comb begin
    stable_level_next   = stable_level;
    debouncing_next     = debouncing;
    debounce_count_next = debounce_count;
    toggle              = 1'b0;
    if (debouncing) begin
      if (debounce_count[TIMER_BITS-1:1] == '0) begin
        debouncing_next     = 1'b0;
        debounce_count_next = '0;
        if (level != stable_level) begin
          stable_level_next = level;
          toggle            = 1'b1;
        end
      end else begin
        debounce_count_next = debounce_count - TIMER_BITS'(1);
      end
    end else if (level != previous_raw) begin
      debouncing_next     = 1'b1;
      debounce_count_next = debounce_ticks;
    end
  end

  assign evt.toggle = toggle;

  // Advance only on an accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw   <= 1'b1;
      stable_level   <= 1'b1;
      debouncing     <= 1'b0;
      debounce_count <= '0;
    end else if (take) begin
      previous_raw   <= level;
      stable_level   <= stable_level_next;
      debouncing     <= debouncing_next;
      debounce_count <= debounce_count_next;
    end
  end

endmodule

### rtl/stpd_queue.sv
module stpd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  stpd_pkg::tick_evt_t push_evt,
  input  logic                pop,
  output stpd_pkg::tick_evt_t pop_evt,
  output logic                empty,
  output logic                full
);

  stpd_pkg::tick_evt_t entries [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          fill;

  assign empty   = (fill == 2'd0);
  assign full    = (fill == 2'd2);
  assign pop_evt = entries[rd_ptr];

  // Store incoming tick events
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_evt;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

### rtl/stpd_back.sv
module stpd_back #(
  parameter int CMD_BITS   = 32,
  parameter int TIMER_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  evt_avail,
  input  stpd_pkg::tick_evt_t                   evt,
  output logic                                  evt_pop,
  input  logic [TIMER_BITS-1:0]                 short_wait_ticks,
  input  logic [TIMER_BITS-1:0]                 long_extra_ticks,
  output logic                                  cmd_valid,
  input  logic                                  cmd_stall,
  output logic [stpd_pkg::OUT_CMD_BITS-1:0]     command,
  output logic                                  overflowed
);

  stpd_pkg::wait_mode_t  wait_mode;
  logic [TIMER_BITS-1:0] wait_count;
  logic [CMD_BITS-1:0]   command_shift;
  logic                  lost_bits;

  stpd_pkg::wait_mode_t  wait_mode_next;
  logic [TIMER_BITS-1:0] wait_count_next;
  logic [CMD_BITS-1:0]   command_shift_next;
  logic                  lost_bits_next;
  logic                  emit;
  logic                  wait_done;
  logic [stpd_pkg::WIDE_BITS-1:0] cmd_wide;

  // Take the next tick once the output slot can hold a result
  assign evt_pop   = evt_avail && !(cmd_valid && cmd_stall);
  assign wait_done = (wait_count[TIMER_BITS-1:1] == '0);
  assign cmd_wide  = stpd_pkg::WIDE_BITS'(command_shift);

  // Gap timer first, then the toggle
  always_comb begin
    wait_mode_next     = wait_mode;
    wait_count_next    = wait_count;
    command_shift_next = command_shift;
    lost_bits_next     = lost_bits;
    emit               = 1'b0;

    unique case (wait_mode)
      stpd_pkg::MODE_SHORT: begin
        if (wait_done) begin
          wait_mode_next  = stpd_pkg::MODE_LONG;
          wait_count_next = long_extra_ticks;
        end else begin
          wait_count_next = wait_count - TIMER_BITS'(1);
        end
      end
      stpd_pkg::MODE_LONG: begin
        if (wait_done) begin
          emit               = 1'b1;
          command_shift_next = '0;
          lost_bits_next     = 1'b0;
          wait_mode_next     = stpd_pkg::MODE_IDLE;
          wait_count_next    = '0;
        end else begin
          wait_count_next = wait_count - TIMER_BITS'(1);
        end
      end
      default: begin
      end
    endcase

    if (evt.toggle) begin
      unique case (wait_mode_next) inside
        stpd_pkg::MODE_IDLE, stpd_pkg::MODE_SHORT: begin
          lost_bits_next     = lost_bits_next | command_shift_next[CMD_BITS-1];
          command_shift_next = {command_shift_next[CMD_BITS-2:0], 1'b1};
          wait_mode_next     = stpd_pkg::MODE_SHORT;
          wait_count_next    = short_wait_ticks;
        end
        stpd_pkg::MODE_LONG: begin
          lost_bits_next     = lost_bits_next |
                               (|command_shift_next[CMD_BITS-1:CMD_BITS-2]);
          command_shift_next = {command_shift_next[CMD_BITS-3:0], 2'b01};
          wait_mode_next     = stpd_pkg::MODE_SHORT;
          wait_count_next    = short_wait_ticks;
        end
        default: begin
        end
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_mode     <= stpd_pkg::MODE_IDLE;
      wait_count    <= '0;
      command_shift <= '0;
      lost_bits     <= 1'b0;
    end else if (evt_pop) begin
      wait_mode     <= wait_mode_next;
      wait_count    <= wait_count_next;
      command_shift <= command_shift_next;
      lost_bits     <= lost_bits_next;
    end
  end

  // Output register: load on emit, drop once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (evt_pop && emit) begin
      cmd_valid <= 1'b1;
    end else if (!cmd_stall) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_pop && emit) begin
      command    <= cmd_wide[stpd_pkg::OUT_CMD_BITS-1:0];
      overflowed <= lost_bits | (|cmd_wide[stpd_pkg::WIDE_BITS-1:stpd_pkg::OUT_CMD_BITS]);
    end
  end

endmodule
